// ----- rtl/core/dsl_pkg.sv -----
// Shared constants and helpers for the decimal seven-segment layout block.
// Used by dsl_div10 and decimal_seven_segment_layout; depends on nothing.
`default_nettype none

package dsl_pkg;

    // Field widths
    localparam int VALUE_W  = 32;
    localparam int COORD_W  = 12;
    localparam int SIZE_W   = 10;
    localparam int DIGIT_W  = 4;
    localparam int MASK_W   = 7;
    localparam int POS_W    = 15;

    // Digit storage and count
    localparam int DIGIT_SLOTS    = 10;
    localparam int MAX_DIGITS_OUT = 10;
    localparam int IDX_W          = $clog2(DIGIT_SLOTS);
    localparam int CNT_W          = $clog2(DIGIT_SLOTS + 1);

    // Divide by ten through a reciprocal multiply: q = (v * RECIP10) >> 35
    localparam int                 QUO_W      = 29;
    localparam int                 PROD_W     = 64;
    localparam int                 DIV_SHIFT  = 35;
    localparam logic [VALUE_W-1:0] RECIP10    = 32'hCCCC_CCCD;

    // Divide by three for the inter-digit gap: gap = (len * 683) >> 11
    localparam int                 GAP_W      = 9;
    localparam int                 GAP_PROD_W = 21;
    localparam int                 GAP_SHIFT  = 11;
    localparam logic [GAP_PROD_W-1:0] RECIP3  = 21'd683;

    localparam int STEP_W = 11;

    // Segment order: top, upper-left, upper-right, middle,
    // lower-left, lower-right, bottom
    function automatic logic [MASK_W-1:0] seg_mask(input logic [DIGIT_W-1:0] digit);
        logic [MASK_W-1:0] mask;
        unique case (digit)
            4'd0:    mask = 7'h77;
            4'd1:    mask = 7'h24;
            4'd2:    mask = 7'h5D;
            4'd3:    mask = 7'h6D;
            4'd4:    mask = 7'h2E;
            4'd5:    mask = 7'h6B;
            4'd6:    mask = 7'h7B;
            4'd7:    mask = 7'h25;
            4'd8:    mask = 7'h7F;
            4'd9:    mask = 7'h6F;
            default: mask = '0;
        endcase
        return mask;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/decimal_seven_segment_layout.sv -----
// Decimal seven-segment layout: top level with sequencer, digit store and placement.
// Depends on dsl_pkg and dsl_div10.
`default_nettype none

// Pulse start while busy is low to issue a request. The number is split into
// decimal digits, least significant first; each digit leaves on the o_ ports
// for exactly one cycle, marked by o_strobe, and the receiver cannot hold it
// off. For a number of n digits (n = 1..10) busy stays high while the number
// is split through the shared divide-by-ten multiplier (S_MUL then S_REM for
// each digit), the first digit is placed and the digits go out. The strobes of
// one request come on consecutive cycles, the last carrying o_last_digit.

module decimal_seven_segment_layout (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [dsl_pkg::VALUE_W-1:0]     i_value,
    input  wire logic [dsl_pkg::COORD_W-1:0]     i_origin_x,
    input  wire logic [dsl_pkg::COORD_W-1:0]     i_origin_y,
    input  wire logic [dsl_pkg::SIZE_W-1:0]      i_digit_size,
    output logic                                 o_strobe,
    output logic      [dsl_pkg::DIGIT_W-1:0]     o_digit_value,
    output logic      [dsl_pkg::MASK_W-1:0]      o_segment_mask,
    output logic      [dsl_pkg::POS_W-1:0]       o_pos_x,
    output logic      [dsl_pkg::COORD_W-1:0]     o_pos_y,
    output logic                                 o_last_digit
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_REM   = 5'b00100,
        S_PLACE = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [dsl_pkg::VALUE_W-1:0]  r_val;
    logic [dsl_pkg::COORD_W-1:0]  r_origin_x;
    logic [dsl_pkg::COORD_W-1:0]  r_origin_y;
    logic [dsl_pkg::SIZE_W-1:0]   r_len;
    logic [dsl_pkg::GAP_W-1:0]    r_gap;
    logic [dsl_pkg::CNT_W-1:0]    r_cnt;
    logic [dsl_pkg::CNT_W-1:0]    r_emit;
    logic [dsl_pkg::IDX_W-1:0]    r_idx;
    logic [dsl_pkg::POS_W-1:0]    r_pos;
    logic [dsl_pkg::DIGIT_W-1:0]  r_dig [dsl_pkg::DIGIT_SLOTS];

    logic                         accept;
    logic [dsl_pkg::GAP_PROD_W-1:0] w_gap_prod;
    logic [dsl_pkg::STEP_W-1:0]   w_step;
    logic [dsl_pkg::POS_W-1:0]    w_span;
    logic [dsl_pkg::QUO_W-1:0]    w_quo;
    logic [dsl_pkg::DIGIT_W-1:0]  w_rem;
    logic                         w_split_done;
    logic                         w_emit_last;
    logic [dsl_pkg::DIGIT_W-1:0]  w_digit;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Shared divide-by-ten unit
    dsl_div10 u_div10 (
        .i_clk       (i_clk),
        .i_load      (r_state == S_MUL),
        .i_dividend  (r_val),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // Gap is floor(len/3); digits step left by len+gap
    assign w_gap_prod   = dsl_pkg::GAP_PROD_W'(i_digit_size) * dsl_pkg::RECIP3;
    assign w_step       = dsl_pkg::STEP_W'(r_len) + dsl_pkg::STEP_W'(r_gap);
    assign w_span       = dsl_pkg::POS_W'(r_cnt) * dsl_pkg::POS_W'(w_step);
    assign w_split_done = (w_quo == '0)
                       || (r_cnt == dsl_pkg::CNT_W'(dsl_pkg::DIGIT_SLOTS - 1));
    assign w_emit_last  = (dsl_pkg::CNT_W'(r_idx) == r_emit - 1'b1);
    assign w_digit      = r_dig[r_idx];

    // Sequence the request: split, place, emit
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_MUL;
            S_MUL:   n_state = S_REM;
            S_REM:   n_state = w_split_done ? S_PLACE : S_MUL;
            S_PLACE: n_state = S_EMIT;
            S_EMIT:  if (w_emit_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= (r_state == S_EMIT);
        end
    end

    // Hold request fields, store digits, advance the emit position
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_val      <= i_value;
            r_origin_x <= i_origin_x;
            r_origin_y <= i_origin_y;
            r_len      <= i_digit_size;
            r_gap      <= w_gap_prod[dsl_pkg::GAP_SHIFT +: dsl_pkg::GAP_W];
            r_cnt      <= '0;
        end
        if (r_state == S_REM) begin
            r_dig[r_cnt[dsl_pkg::IDX_W-1:0]] <= w_rem;
            r_val <= dsl_pkg::VALUE_W'(w_quo);
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_state == S_PLACE) begin
            r_pos  <= dsl_pkg::POS_W'(r_origin_x) + w_span - dsl_pkg::POS_W'(r_gap);
            r_idx  <= '0;
            r_emit <= (r_cnt > dsl_pkg::CNT_W'(dsl_pkg::MAX_DIGITS_OUT))
                    ? dsl_pkg::CNT_W'(dsl_pkg::MAX_DIGITS_OUT) : r_cnt;
        end
        if (r_state == S_EMIT) begin
            r_pos          <= r_pos - dsl_pkg::POS_W'(w_step);
            r_idx          <= r_idx + 1'b1;
            o_digit_value  <= w_digit;
            o_segment_mask <= dsl_pkg::seg_mask(w_digit);
            o_pos_x        <= r_pos;
            o_pos_y        <= r_origin_y;
            o_last_digit   <= w_emit_last;
        end
    end

    // Checks
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after accepted request");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_digit) |=> !o_strobe)
        else $error("strobe continues past last digit");

    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_digit) |=> o_strobe)
        else $error("digit run broken before last digit");

    a_digit_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_digit_value <= 4'd9))
        else $error("emitted digit is not decimal");

endmodule

`default_nettype wire

// ----- rtl/core/dsl_div10.sv -----
// Shared divide-by-ten unit: registers a reciprocal product, then yields
// quotient and remainder on the next cycle. Depends on dsl_pkg.
`default_nettype none

module dsl_div10 (
    input  wire logic                            i_clk,
    input  wire logic                            i_load,
    input  wire logic [dsl_pkg::VALUE_W-1:0]     i_dividend,
    output logic      [dsl_pkg::QUO_W-1:0]       o_quotient,
    output logic      [dsl_pkg::DIGIT_W-1:0]     o_remainder
);

    logic [dsl_pkg::PROD_W-1:0]  r_prod;
    logic [dsl_pkg::VALUE_W-1:0] r_dividend;
    logic [dsl_pkg::VALUE_W:0]   w_quo_x10;

    // Capture dividend and its reciprocal product
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod     <= dsl_pkg::PROD_W'(i_dividend) * dsl_pkg::PROD_W'(dsl_pkg::RECIP10);
            r_dividend <= i_dividend;
        end
    end

    // Take the quotient from the product, recover the remainder
    assign o_quotient  = r_prod[dsl_pkg::PROD_W-1:dsl_pkg::DIV_SHIFT];
    assign w_quo_x10   = ({4'b0, o_quotient} << 3) + ({4'b0, o_quotient} << 1);
    assign o_remainder = r_dividend[dsl_pkg::DIGIT_W-1:0]
                       - w_quo_x10[dsl_pkg::DIGIT_W-1:0];

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for decimal_seven_segment_layout: random and corner-case requests
// checked digit by digit against an in-bench layout predictor. Depends on dsl_pkg and the RTL.
`default_nettype none

module testbench;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_REQS  = 230;
    localparam int IDLE_PCT_A   = 18;
    localparam int IDLE_PCT_B   = 49;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    // Segment masks packed by digit, digit 0 in the low bits
    localparam logic [10*dsl_pkg::MASK_W-1:0] SEG_TABLE = {
        7'h6F, 7'h7F, 7'h25, 7'h7B, 7'h6B, 7'h2E, 7'h6D, 7'h5D, 7'h24, 7'h77
    };

    typedef struct {
        logic [dsl_pkg::VALUE_W-1:0] value;
        logic [dsl_pkg::COORD_W-1:0] origin_x;
        logic [dsl_pkg::COORD_W-1:0] origin_y;
        logic [dsl_pkg::SIZE_W-1:0]  digit_size;
        int                          idle_pct;
        bit                          wait_drain;
    } t_layout_req;

    typedef struct {
        logic [dsl_pkg::DIGIT_W-1:0] digit;
        logic [dsl_pkg::MASK_W-1:0]  mask;
        logic [dsl_pkg::POS_W-1:0]   pos_x;
        logic [dsl_pkg::COORD_W-1:0] pos_y;
        logic                        last;
    } t_digit_exp;

    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         start        = 1'b0;
    logic [dsl_pkg::VALUE_W-1:0]  i_value      = '0;
    logic [dsl_pkg::COORD_W-1:0]  i_origin_x   = '0;
    logic [dsl_pkg::COORD_W-1:0]  i_origin_y   = '0;
    logic [dsl_pkg::SIZE_W-1:0]   i_digit_size = '0;
    logic                         busy;
    logic                         o_strobe;
    logic [dsl_pkg::DIGIT_W-1:0]  o_digit_value;
    logic [dsl_pkg::MASK_W-1:0]   o_segment_mask;
    logic [dsl_pkg::POS_W-1:0]    o_pos_x;
    logic [dsl_pkg::COORD_W-1:0]  o_pos_y;
    logic                         o_last_digit;

    t_layout_req pending_reqs[$];
    t_layout_req cur_req;
    t_digit_exp  digit_q[$];
    t_digit_exp  want;
    int          mismatch_cnt = 0;
    int          cycle_cnt    = 0;

    decimal_seven_segment_layout DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .i_origin_x     (i_origin_x),
        .i_origin_y     (i_origin_y),
        .i_digit_size   (i_digit_size),
        .o_strobe       (o_strobe),
        .o_digit_value  (o_digit_value),
        .o_segment_mask (o_segment_mask),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_last_digit   (o_last_digit)
    );

    // Split a request into its digits and queue the expected layout
    task automatic predict_digits(input t_layout_req req);
        logic [dsl_pkg::DIGIT_W-1:0] digs [0:dsl_pkg::DIGIT_SLOTS-1];
        logic [dsl_pkg::VALUE_W-1:0] rem;
        int unsigned                 count;
        int unsigned                 emit;
        int unsigned                 gap;
        int unsigned                 pos;
        t_digit_exp                  d;
        rem     = req.value;
        digs[0] = dsl_pkg::DIGIT_W'(rem % 10);
        rem     = rem / 10;
        count   = 1;
        while (rem != 0 && count < dsl_pkg::DIGIT_SLOTS) begin
            digs[count] = dsl_pkg::DIGIT_W'(rem % 10);
            rem         = rem / 10;
            count++;
        end
        emit = (count > dsl_pkg::MAX_DIGITS_OUT) ? dsl_pkg::MAX_DIGITS_OUT : count;
        gap  = req.digit_size / 3;
        pos  = req.origin_x + count * req.digit_size + (count - 1) * gap;
        for (int k = 0; k < emit; k++) begin
            d.digit = digs[k];
            d.mask  = SEG_TABLE[digs[k]*dsl_pkg::MASK_W +: dsl_pkg::MASK_W];
            d.pos_x = dsl_pkg::POS_W'(pos);
            d.pos_y = req.origin_y;
            d.last  = (k + 1 == emit);
            digit_q.push_back(d);
            pos = pos - (req.digit_size + gap);
        end
    endtask

    task automatic add_req(input logic [dsl_pkg::VALUE_W-1:0] value,
                           input logic [dsl_pkg::COORD_W-1:0] ox,
                           input logic [dsl_pkg::COORD_W-1:0] oy,
                           input logic [dsl_pkg::SIZE_W-1:0] size,
                           input int idle_pct, input bit wait_drain);
        t_layout_req r;
        r.value      = value;
        r.origin_x   = ox;
        r.origin_y   = oy;
        r.digit_size = size;
        r.idle_pct   = idle_pct;
        r.wait_drain = wait_drain;
        pending_reqs.push_back(r);
    endtask

    // Clock and one reset pulse at the start
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Driver: on acceptance predict, then launch the next request or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (start) begin
                predict_digits(cur_req);
            end
            if (pending_reqs.size() != 0 &&
                $urandom_range(99) >= pending_reqs[0].idle_pct &&
                (!pending_reqs[0].wait_drain || digit_q.size() == 0)) begin
                cur_req = pending_reqs.pop_front();
                start        <= 1'b1;
                i_value      <= cur_req.value;
                i_origin_x   <= cur_req.origin_x;
                i_origin_y   <= cur_req.origin_y;
                i_digit_size <= cur_req.digit_size;
            end else begin
                // Hold start low and put noise on the payload
                start        <= 1'b0;
                i_value      <= $urandom();
                i_origin_x   <= dsl_pkg::COORD_W'($urandom());
                i_origin_y   <= dsl_pkg::COORD_W'($urandom());
                i_digit_size <= dsl_pkg::SIZE_W'($urandom());
            end
        end
    end

    // Monitor: compare each strobed digit with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            if (digit_q.size() == 0) begin
                $error("unexpected digit: digit_value %0d pos_x %0d", o_digit_value, o_pos_x);
                mismatch_cnt <= mismatch_cnt + 1;
            end else begin
                want = digit_q.pop_front();
                if (o_digit_value !== want.digit || o_segment_mask !== want.mask ||
                    o_pos_x !== want.pos_x || o_pos_y !== want.pos_y ||
                    o_last_digit !== want.last) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                end
                if (o_digit_value !== want.digit)
                    $error("digit_value: expected %0d, got %0d", want.digit, o_digit_value);
                if (o_segment_mask !== want.mask)
                    $error("segment_mask: expected %h, got %h", want.mask, o_segment_mask);
                if (o_pos_x !== want.pos_x)
                    $error("pos_x: expected %0d, got %0d", want.pos_x, o_pos_x);
                if (o_pos_y !== want.pos_y)
                    $error("pos_y: expected %0d, got %0d", want.pos_y, o_pos_y);
                if (o_last_digit !== want.last)
                    $error("last_digit: expected %0d, got %0d", want.last, o_last_digit);
            end
        end
    end

    // Stimulus and end of run
    initial begin
        longint unsigned             lo;
        longint unsigned             hi;
        int                          ndig;
        int                          idle;
        logic [dsl_pkg::VALUE_W-1:0] v;
        logic [dsl_pkg::SIZE_W-1:0]  sz;

        // Corner cases: zero, digit boundaries, every digit, zero and extreme sizes
        add_req(32'd0,          12'd0,    12'd0,    10'd1,    IDLE_PCT_A, 1'b0);
        add_req(32'd0,          12'd4095, 12'd4095, 10'd0,    IDLE_PCT_A, 1'b0);
        add_req(32'd9,          12'd100,  12'd200,  10'd3,    IDLE_PCT_A, 1'b0);
        add_req(32'd10,         12'd0,    12'd4095, 10'd2,    IDLE_PCT_A, 1'b0);
        add_req(32'd99,         12'd17,   12'd33,   10'd1023, IDLE_PCT_A, 1'b0);
        add_req(32'd100,        12'd5,    12'd5,    10'd4,    IDLE_PCT_A, 1'b0);
        add_req(32'd1000,       12'd0,    12'd0,    10'd0,    IDLE_PCT_A, 1'b0);
        add_req(32'd1234567890, 12'd64,   12'd128,  10'd12,   IDLE_PCT_A, 1'b0);
        add_req(32'd987654321,  12'd2048, 12'd1024, 10'd7,    IDLE_PCT_A, 1'b0);
        add_req(32'd999999999,  12'd1,    12'd2,    10'd6,    IDLE_PCT_A, 1'b0);
        add_req(32'd1000000000, 12'd3,    12'd4,    10'd5,    IDLE_PCT_A, 1'b0);
        add_req(32'hFFFF_FFFF,  12'd4095, 12'd4095, 10'd1023, IDLE_PCT_A, 1'b0);
        add_req(32'hFFFF_FFFF,  12'd0,    12'd0,    10'd0,    IDLE_PCT_A, 1'b0);
        add_req(32'd4294967290, 12'd4095, 12'd0,    10'd1022, IDLE_PCT_A, 1'b1);
        add_req(32'd7,          12'd4095, 12'd4095, 10'd1023, IDLE_PCT_A, 1'b0);
        add_req(32'd5018,       12'd2730, 12'd1365, 10'd682,  IDLE_PCT_A, 1'b0);
        add_req(32'd60,         12'd1365, 12'd2730, 10'd341,  IDLE_PCT_A, 1'b0);

        // Random requests in three idling phases, digit count spread evenly for most of them
        for (int i = 0; i < RANDOM_REQS; i++) begin
            idle = (i < RANDOM_REQS / 3) ? IDLE_PCT_A :
                   (i < 2 * RANDOM_REQS / 3) ? IDLE_PCT_B : 0;
            if ($urandom_range(7) == 0) begin
                v = $urandom();
            end else begin
                ndig = $urandom_range(10, 1);
                lo   = 1;
                repeat (ndig - 1) lo = lo * 10;
                hi   = lo * 10 - 1;
                if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
                if (ndig == 1) lo = 0;
                v = $urandom_range(dsl_pkg::VALUE_W'(hi), dsl_pkg::VALUE_W'(lo));
            end
            sz = ($urandom_range(15) == 0) ? '0 : dsl_pkg::SIZE_W'($urandom_range(1023, 1));
            add_req(v, dsl_pkg::COORD_W'($urandom()), dsl_pkg::COORD_W'($urandom()), sz,
                    idle,
                    (i == RANDOM_REQS / 3) || (i == 2 * RANDOM_REQS / 3) ||
                    ($urandom_range(99) < 3));
        end

        // Wait for all requests to go in and all digits to come out
        while ((pending_reqs.size() != 0 || start || digit_q.size() != 0) &&
               cycle_cnt < CYCLE_LIMIT)
            @(posedge i_clk);

        if (cycle_cnt >= CYCLE_LIMIT) begin
            $error("timeout: %0d digits still expected", digit_q.size());
            $display("FAIL decimal_seven_segment_layout");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            if (mismatch_cnt == 0 && digit_q.size() == 0) begin
                $display("PASS decimal_seven_segment_layout");
            end else begin
                $display("FAIL decimal_seven_segment_layout");
            end
        end
        $finish;
    end

endmodule

`default_nettype wire
